// ----- design/mtb_pkg.sv -----
// Shared types and constants for the millisecond timebase.
// Used by mtb_cfg, mtb_core and the top level; depends on nothing.
package mtb_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] REG_SCREEN_TIMEOUT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_ADC_ENABLED = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ADC_INTERVAL = 2'd2;

	localparam int unsigned InDataW = 8;
	localparam int unsigned OutDataW = 192;

	localparam logic [15:0] MINUTE_MS = 16'd60000;
	localparam logic [9:0] SEC_MS = 10'd1000;
	localparam logic [3:0] CSEC_TICKS = 4'd10;
	localparam logic [31:0] FOLD_LIMIT = 32'hFFFF_E000;
	localparam logic [31:0] FOLD_AMOUNT = 32'hFFFF_0000;
	localparam logic [14:0] IDLE_MAX = 15'h7FFF;

	typedef struct packed {
		logic [14:0] screen_timeout_minutes;
		logic adc_enabled;
		logic [15:0] adc_interval;
	} cfg_t;

	typedef struct packed {
		logic tick;
		logic key_press;
		logic second_pulse;
		logic clear_display;
		logic set_display;
		logic clear_msec;
		logic reset_sec;
		logic reset_minute;
	} strobe_t;

	typedef struct packed {
		logic [31:0] msec_stamp;
		logic [31:0] csec_stamp;
		logic [31:0] tick_count;
		logic [9:0] sec_phase;
		logic [15:0] minute_phase;
		logic [31:0] low_clock_seconds;
		logic [31:0] wall_clock_seconds;
		logic display_flag;
		logic screen_active;
		logic adc_service;
		logic tick_rollover;
	} result_t;

endpackage

// ----- design/mtb_cfg.sv -----
// Configuration registers of the millisecond timebase.
// Decodes register writes by index; depends on mtb_pkg.
module mtb_cfg import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SCREEN_TIMEOUT: cfg_q.screen_timeout_minutes <= wr_data[14:0];
				REG_ADC_ENABLED: cfg_q.adc_enabled <= wr_data[0];
				REG_ADC_INTERVAL: cfg_q.adc_interval <= wr_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/mtb_core.sv -----
// Timebase state and its one-pass update for a request.
// Holds all counters and flags; depends on mtb_pkg.
module mtb_core import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  strobe_t strobe,
	input  cfg_t cfg,
	output result_t result
);

	logic [31:0] msec_q, csec_q, tick_total_q, low_clock_q, wall_clock_q;
	logic [3:0] csec_div_q;
	logic [9:0] sec_phase_q, clock_div_q;
	logic [15:0] minute_phase_q;
	logic display_q, screen_on_q;
	logic [14:0] idle_q;
	logic [15:0] adc_cnt_q;

	logic [31:0] msec_d, csec_d, tick_total_d, low_clock_d, wall_clock_d, tick_inc;
	logic [3:0] csec_div_d;
	logic [9:0] sec_phase_d, clock_div_d;
	logic [15:0] minute_phase_d;
	logic display_d, screen_on_d, adc_pulse, rollover, minute_flag;
	logic [14:0] idle_d;
	logic [15:0] adc_cnt_d;

	always_comb begin
		msec_d = strobe.clear_msec ? 32'd0 : msec_q;
		sec_phase_d = strobe.reset_sec ? 10'd0 : sec_phase_q;
		minute_phase_d = strobe.reset_minute ? 16'd0 : minute_phase_q;
		csec_d = csec_q;
		csec_div_d = csec_div_q;
		clock_div_d = clock_div_q;
		low_clock_d = low_clock_q;
		tick_total_d = tick_total_q;
		tick_inc = tick_total_q + 32'd1;
		adc_cnt_d = adc_cnt_q;
		adc_pulse = 1'b0;
		rollover = 1'b0;
		minute_flag = 1'b0;
		screen_on_d = screen_on_q;
		idle_d = idle_q;

		// key press wakes the screen only when a timeout is armed
		if (strobe.key_press && cfg.screen_timeout_minutes != '0) begin
			screen_on_d = 1'b1;
			idle_d = '0;
		end

		if (strobe.tick) begin
			msec_d = msec_d + 32'd1;
			if (minute_phase_d + 16'd1 >= MINUTE_MS) begin
				minute_phase_d = '0;
				minute_flag = 1'b1;
			end else begin
				minute_phase_d = minute_phase_d + 16'd1;
			end
			if (clock_div_q + 10'd1 >= SEC_MS) begin
				clock_div_d = '0;
				low_clock_d = low_clock_q + 32'd1;
			end else begin
				clock_div_d = clock_div_q + 10'd1;
			end
			if (csec_div_q + 4'd1 >= CSEC_TICKS) begin
				csec_div_d = '0;
				csec_d = csec_q + 32'd1;
			end else begin
				csec_div_d = csec_div_q + 4'd1;
			end
			if (sec_phase_d + 10'd1 >= SEC_MS) begin
				sec_phase_d = '0;
			end else begin
				sec_phase_d = sec_phase_d + 10'd1;
			end
			// fold the tick counter back once it passes the limit
			if (tick_inc > FOLD_LIMIT) begin
				tick_total_d = tick_inc - FOLD_AMOUNT;
				rollover = 1'b1;
			end else begin
				tick_total_d = tick_inc;
			end
			if (cfg.adc_enabled) begin
				if (adc_cnt_q != '0) begin
					adc_cnt_d = adc_cnt_q - 16'd1;
				end else begin
					adc_pulse = 1'b1;
					adc_cnt_d = cfg.adc_interval;
				end
			end
			if (minute_flag && screen_on_d && cfg.screen_timeout_minutes != '0) begin
				if (idle_d != IDLE_MAX) begin
					idle_d = idle_d + 15'd1;
				end
				if (idle_d >= cfg.screen_timeout_minutes) begin
					screen_on_d = 1'b0;
				end
			end
		end

		display_d = display_q;
		if (strobe.clear_display) begin
			display_d = 1'b0;
		end
		if (strobe.set_display || strobe.second_pulse) begin
			display_d = 1'b1;
		end
		wall_clock_d = strobe.second_pulse ? wall_clock_q + 32'd1 : wall_clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msec_q <= '0;
			csec_q <= '0;
			csec_div_q <= '0;
			tick_total_q <= '0;
			sec_phase_q <= '0;
			clock_div_q <= '0;
			minute_phase_q <= '0;
			low_clock_q <= '0;
			wall_clock_q <= '0;
			display_q <= 1'b1;
			screen_on_q <= 1'b1;
			idle_q <= '0;
			adc_cnt_q <= '0;
		end else if (advance) begin
			msec_q <= msec_d;
			csec_q <= csec_d;
			csec_div_q <= csec_div_d;
			tick_total_q <= tick_total_d;
			sec_phase_q <= sec_phase_d;
			clock_div_q <= clock_div_d;
			minute_phase_q <= minute_phase_d;
			low_clock_q <= low_clock_d;
			wall_clock_q <= wall_clock_d;
			display_q <= display_d;
			screen_on_q <= screen_on_d;
			idle_q <= idle_d;
			adc_cnt_q <= adc_cnt_d;
		end
	end

	always_comb begin
		result.msec_stamp = msec_d;
		result.csec_stamp = csec_d;
		result.tick_count = tick_total_d;
		result.sec_phase = sec_phase_d;
		result.minute_phase = minute_phase_d;
		result.low_clock_seconds = low_clock_d;
		result.wall_clock_seconds = wall_clock_d;
		result.display_flag = display_d;
		result.screen_active = screen_on_d;
		result.adc_service = adc_pulse;
		result.tick_rollover = rollover;
	end

endmodule

// ----- design/millisecond_timebase_with_idle_timeout_unit.sv -----
// Millisecond timebase with screen idle timeout: top level.
// A request is taken into the input register, then its result into the result register;
// one request per cycle sustained while the result side does not stall.
// The state update runs in a single pass between the two registers.
// Reset (arst_n low) clears all counters, config and valids; display and
// screen flags come up set. Config writes are always ready.
module millisecond_timebase_with_idle_timeout_unit import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [0] tick, [1] key_press, [2] second_pulse, [3] clear_display,
	// [4] set_display, [5] clear_msec, [6] reset_sec, [7] reset_minute
	input  logic [InDataW-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [31:0] msec_stamp, [63:32] csec_stamp, [95:64] tick_count,
	// [105:96] sec_phase, [121:106] minute_phase, [153:122] low_clock_seconds,
	// [185:154] wall_clock_seconds, [186] display_flag, [187] screen_active,
	// [188] adc_service, [189] tick_rollover, [191:190] zero
	output logic [OutDataW-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg;
	strobe_t strobe_s1;
	logic valid_s1;
	logic out_valid_q;
	result_t result, result_q;
	logic advance;

	assign cfg_ready = 1'b1;

	mtb_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid & cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	// move the held request into the result register when that slot frees
	assign advance = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			strobe_s1.tick <= s_axis_tdata[0];
			strobe_s1.key_press <= s_axis_tdata[1];
			strobe_s1.second_pulse <= s_axis_tdata[2];
			strobe_s1.clear_display <= s_axis_tdata[3];
			strobe_s1.set_display <= s_axis_tdata[4];
			strobe_s1.clear_msec <= s_axis_tdata[5];
			strobe_s1.reset_sec <= s_axis_tdata[6];
			strobe_s1.reset_minute <= s_axis_tdata[7];
		end
	end

	mtb_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.strobe(strobe_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, result_q.tick_rollover, result_q.adc_service,
		result_q.screen_active, result_q.display_flag, result_q.wall_clock_seconds,
		result_q.low_clock_seconds, result_q.minute_phase, result_q.sec_phase,
		result_q.tick_count, result_q.csec_stamp, result_q.msec_stamp};

endmodule

// ----- bench/timebase_checker.sv -----
`timescale 1ns / 100ps
// Checker for the millisecond timebase: follows register writes, predicts the result of
// every accepted request and compares the results field by field, oldest first.
// Depends on mtb_pkg for widths, register indexes and the strobe and result types.
module timebase_checker import mtb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [InDataW-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [OutDataW-1:0] m_axis_tdata,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	output int fail_count,
	output int pending_count
);

	localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;
	localparam logic [3:0] TICKS_PER_CSEC = 4'd10;
	localparam logic [31:0] FOLD_THRESHOLD = 32'hFFFF_E000;
	localparam logic [31:0] FOLD_STEP = 32'hFFFF_0000;
	localparam logic [14:0] IDLE_CEILING = 15'h7FFF;
	localparam int FIELD_COUNT = 12;

	// register copies
	logic [14:0] timeout_mins;
	logic adc_on;
	logic [15:0] adc_reload;

	// timebase state
	logic [31:0] ms_stamp, cs_stamp, ticks_seen, secs_from_ticks, secs_from_pulses;
	logic [3:0] cs_prescale;
	logic [9:0] sec_ms, sec_prescale;
	logic [15:0] minute_ms;
	logic refresh_due, screen_lit;
	logic [14:0] idle_mins;
	logic [15:0] adc_wait;

	logic [OutDataW-1:0] expected_results[$];
	logic [OutDataW-1:0] want;
	strobe_t req;
	result_t res;
	int results_seen;

	task automatic advance_timebase(input strobe_t s, output result_t r);
		logic minute_done, adc_fire, folded;
		minute_done = 1'b0;
		adc_fire = 1'b0;
		folded = 1'b0;
		if (s.clear_msec)
			ms_stamp = '0;
		if (s.reset_sec)
			sec_ms = '0;
		if (s.reset_minute)
			minute_ms = '0;
		if (s.key_press && timeout_mins != 0) begin
			screen_lit = 1'b1;
			idle_mins = '0;
		end
		if (s.tick) begin
			ms_stamp = ms_stamp + 32'd1;
			minute_ms = minute_ms + 16'd1;
			if (minute_ms >= MS_PER_MINUTE) begin
				minute_ms = '0;
				minute_done = 1'b1;
			end
			sec_prescale = sec_prescale + 10'd1;
			if (sec_prescale >= MS_PER_SECOND) begin
				secs_from_ticks = secs_from_ticks + 32'd1;
				sec_prescale = '0;
			end
			cs_prescale = cs_prescale + 4'd1;
			if (cs_prescale >= TICKS_PER_CSEC) begin
				cs_stamp = cs_stamp + 32'd1;
				cs_prescale = '0;
			end
			sec_ms = sec_ms + 10'd1;
			if (sec_ms >= MS_PER_SECOND)
				sec_ms = '0;
			// folds back only above the threshold, so the count never reaches all ones
			ticks_seen = ticks_seen + 32'd1;
			if (ticks_seen > FOLD_THRESHOLD) begin
				ticks_seen = ticks_seen - FOLD_STEP;
				folded = 1'b1;
			end
			if (adc_on) begin
				if (adc_wait != 0) begin
					adc_wait = adc_wait - 16'd1;
				end else begin
					adc_fire = 1'b1;
					adc_wait = adc_reload;
				end
			end
			// idle count is held while the screen is off
			if (minute_done && screen_lit && timeout_mins != 0) begin
				if (idle_mins != IDLE_CEILING)
					idle_mins = idle_mins + 15'd1;
				if (idle_mins >= timeout_mins)
					screen_lit = 1'b0;
			end
		end
		if (s.clear_display)
			refresh_due = 1'b0;
		if (s.set_display)
			refresh_due = 1'b1;
		if (s.second_pulse) begin
			secs_from_pulses = secs_from_pulses + 32'd1;
			refresh_due = 1'b1;
		end
		r.msec_stamp = ms_stamp;
		r.csec_stamp = cs_stamp;
		r.tick_count = ticks_seen;
		r.sec_phase = sec_ms;
		r.minute_phase = minute_ms;
		r.low_clock_seconds = secs_from_ticks;
		r.wall_clock_seconds = secs_from_pulses;
		r.display_flag = refresh_due;
		r.screen_active = screen_lit;
		r.adc_service = adc_fire;
		r.tick_rollover = folded;
	endtask

	function automatic int field_lsb(input int i);
		case (i)
			0: return 0;
			1: return 32;
			2: return 64;
			3: return 96;
			4: return 106;
			5: return 122;
			6: return 154;
			7: return 186;
			8: return 187;
			9: return 188;
			10: return 189;
			11: return 190;
			default: return OutDataW;
		endcase
	endfunction

	function automatic string field_name(input int i);
		case (i)
			0: return "msec_stamp";
			1: return "csec_stamp";
			2: return "tick_count";
			3: return "sec_phase";
			4: return "minute_phase";
			5: return "low_clock_seconds";
			6: return "wall_clock_seconds";
			7: return "display_flag";
			8: return "screen_active";
			9: return "adc_service";
			10: return "tick_rollover";
			default: return "padding";
		endcase
	endfunction

	task automatic check_result(input logic [OutDataW-1:0] exp_word,
			input logic [OutDataW-1:0] act_word);
		int lo, w;
		logic [31:0] mask, a, b;
		bit bad;
		bad = 1'b0;
		for (int i = 0; i < FIELD_COUNT; i++) begin
			lo = field_lsb(i);
			w = field_lsb(i + 1) - lo;
			mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
			a = 32'(exp_word >> lo) & mask;
			b = 32'(act_word >> lo) & mask;
			if (a !== b) begin
				bad = 1'b1;
				if (fail_count < 10)
					$display("result %0d: %s expected %0d (0x%h), got %0d (0x%h)",
						results_seen, field_name(i), a, a, b, b);
			end
		end
		if (bad)
			fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_mins = '0;
			adc_on = 1'b0;
			adc_reload = '0;
			ms_stamp = '0;
			cs_stamp = '0;
			cs_prescale = '0;
			ticks_seen = '0;
			sec_ms = '0;
			sec_prescale = '0;
			minute_ms = '0;
			secs_from_ticks = '0;
			secs_from_pulses = '0;
			refresh_due = 1'b1;
			screen_lit = 1'b1;
			idle_mins = '0;
			adc_wait = '0;
			expected_results.delete();
			results_seen = 0;
			fail_count = 0;
			pending_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SCREEN_TIMEOUT: timeout_mins = cfg_data[14:0];
					REG_ADC_ENABLED: adc_on = cfg_data[0];
					REG_ADC_INTERVAL: adc_reload = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("result %0d arrived with no request outstanding: 0x%h",
							results_seen, m_axis_tdata);
					fail_count++;
				end else begin
					check_result(expected_results.pop_front(), m_axis_tdata);
				end
				results_seen++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.tick = s_axis_tdata[0];
				req.key_press = s_axis_tdata[1];
				req.second_pulse = s_axis_tdata[2];
				req.clear_display = s_axis_tdata[3];
				req.set_display = s_axis_tdata[4];
				req.clear_msec = s_axis_tdata[5];
				req.reset_sec = s_axis_tdata[6];
				req.reset_minute = s_axis_tdata[7];
				advance_timebase(req, res);
				want = {2'b00, res.tick_rollover, res.adc_service, res.screen_active,
					res.display_flag, res.wall_clock_seconds, res.low_clock_seconds,
					res.minute_phase, res.sec_phase, res.tick_count, res.csec_stamp,
					res.msec_stamp};
				expected_results.push_back(want);
			end
			pending_count <= expected_results.size();
		end
	end

endmodule

// ----- bench/millisecond_timebase_with_idle_timeout_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the millisecond timebase: drives strobe requests and register writes,
// stalls both stream sides at random and reports the verdict from timebase_checker.
// Depends on mtb_pkg, timebase_checker and the timebase RTL.
module millisecond_timebase_with_idle_timeout_unit_tb import mtb_pkg::*;;

	// strobe positions in s_axis_tdata
	localparam logic [InDataW-1:0] TICK = 8'h01;
	localparam logic [InDataW-1:0] KEY = 8'h02;
	localparam logic [InDataW-1:0] SECOND = 8'h04;
	localparam logic [InDataW-1:0] CLR_DISP = 8'h08;
	localparam logic [InDataW-1:0] SET_DISP = 8'h10;
	localparam logic [InDataW-1:0] CLR_MSEC = 8'h20;
	localparam logic [InDataW-1:0] RST_SEC = 8'h40;
	localparam logic [InDataW-1:0] RST_MIN = 8'h80;
	// index with no register behind it
	localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// [0] tick, [1] key_press, [2] second_pulse, [3] clear_display,
	// [4] set_display, [5] clear_msec, [6] reset_sec, [7] reset_minute
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [31:0] msec_stamp, [63:32] csec_stamp, [95:64] tick_count,
	// [105:96] sec_phase, [121:106] minute_phase, [153:122] low_clock_seconds,
	// [185:154] wall_clock_seconds, [186] display_flag, [187] screen_active,
	// [188] adc_service, [189] tick_rollover, [191:190] zero
	logic [OutDataW-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	int fail_count;
	int pending_count;
	int src_gap_pct = 0;
	int sink_gap_pct = 0;
	int sink_hold = 0;
	int quiet_cycles = 0;
	int requests_sent = 0;
	int settings_applied = 0;

	always #2 clk = ~clk;

	millisecond_timebase_with_idle_timeout_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	timebase_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	// result side: stall in random bursts
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(99) < sink_gap_pct) begin
			sink_hold <= $urandom_range(7);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("no transfer on any channel for %0d cycles, %0d results outstanding",
				STALL_LIMIT, pending_count);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [InDataW-1:0] flags);
		if ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= flags;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
	endtask

	// hold_minute keeps key presses and minute resets out so minute boundaries are reached
	task automatic send_random(input int count, input int tick_pct, input int flag_pct,
			input bit hold_minute);
		logic [InDataW-1:0] flags;
		repeat (count) begin
			flags = '0;
			if ($urandom_range(99) < tick_pct)
				flags |= TICK;
			if (!hold_minute && $urandom_range(99) < flag_pct)
				flags |= KEY;
			if ($urandom_range(99) < flag_pct)
				flags |= SECOND;
			if ($urandom_range(99) < flag_pct)
				flags |= CLR_DISP;
			if ($urandom_range(99) < flag_pct)
				flags |= SET_DISP;
			if ($urandom_range(99) < flag_pct)
				flags |= CLR_MSEC;
			if ($urandom_range(99) < flag_pct)
				flags |= RST_SEC;
			if (!hold_minute && $urandom_range(99) < flag_pct)
				flags |= RST_MIN;
			send_request(flags);
		end
	endtask

	// drop valid and wait until every result is back
	task automatic settle;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_config(input logic [14:0] timeout, input logic adc_on,
			input logic [15:0] interval, input bit poke_spare);
		if (poke_spare)
			write_reg(REG_SPARE, 16'($urandom));
		write_reg(REG_SCREEN_TIMEOUT, {1'b0, timeout});
		write_reg(REG_ADC_ENABLED, {15'd0, adc_on});
		write_reg(REG_ADC_INTERVAL, interval);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: timeout zero so key presses do nothing, ADC service off
		src_gap_pct = 15;
		sink_gap_pct = 15;
		send_request('0);
		send_request(TICK);
		send_request(KEY);
		send_request(SECOND);
		send_request(CLR_DISP);
		send_request(SET_DISP);
		send_request(CLR_DISP | SET_DISP);
		send_request(CLR_DISP | SECOND);
		send_request(CLR_DISP | TICK);
		send_request(CLR_MSEC | TICK);
		send_request(CLR_MSEC);
		send_request(RST_SEC | TICK);
		send_request(RST_MIN | TICK);
		send_request('1);
		send_request(~TICK);
		// ten ticks carry the centisecond stamp over
		repeat (10) send_request(TICK);
		settle();

		// zero interval: a service pulse on every tick
		set_config(15'd2, 1'b1, 16'd0, 1'b1);
		send_random(375, 70, 20, 1'b0);
		settle();

		src_gap_pct = 0;
		sink_gap_pct = 0;
		set_config(15'h7FFF, 1'b1, 16'hFFFF, 1'b0);
		send_random(375, 80, 15, 1'b0);
		settle();

		src_gap_pct = 30;
		sink_gap_pct = 25;
		set_config(15'($urandom_range(1, 32766)), 1'b0, 16'($urandom), 1'b1);
		send_random(375, 50, 30, 1'b0);
		settle();

		src_gap_pct = 10;
		sink_gap_pct = 20;
		set_config(15'd0, 1'b1, 16'($urandom_range(1, 20)), 1'b0);
		send_random(375, 70, 20, 1'b0);
		settle();

		src_gap_pct = 0;
		sink_gap_pct = 0;
		set_config(15'd2, 1'b1, 16'd7, 1'b1);
		send_random(300, 70, 20, 1'b0);
		settle();

		$display("Sent %0d strobe requests under %0d register settings, with random",
			requests_sent, settings_applied);
		$display("stalls on both stream sides and a stall-free final stretch.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
